// File: sv/kvcfp_pkg.sv
// Shared types and constants of the key/value command frame parser.
package kvcfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned SHIFT_W   = 24;   // low three length bytes held while assembling
    localparam int unsigned HDR_IDX_W = 2;
    localparam int unsigned CLASS_W   = 2;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Header byte position of the top length byte.
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 2'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_TAG = 1'b0,
        CFG_DEL_TAG = 1'b1
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] SET_TAG_RESET = 8'd1;
    localparam logic [BYTE_W-1:0] DEL_TAG_RESET = 8'd2;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_KLEN  = 3'd1,
        PH_KDATA = 3'd2,
        PH_VLEN  = 3'd3,
        PH_VDATA = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    // Byte classes.
    localparam logic [CLASS_W-1:0] CLS_HEADER = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_KEY    = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_VALUE  = 2'd2;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

    // Frame parse state.
    typedef struct packed {
        t_phase                 phase;
        logic [KIND_W-1:0]      kind;
        logic [SHIFT_W-1:0]     len_shift;
        logic [HDR_IDX_W-1:0]   hdr_idx;
        logic [LEN_W-1:0]       remaining;
        logic                   err;
    } t_parse_state;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [CLASS_W-1:0] byte_class;
        logic [KIND_W-1:0]  command_kind;
        logic               frame_done;
        logic               frame_ok;
    } t_result;

    // Tag codes from the configuration registers.
    typedef struct packed {
        logic [BYTE_W-1:0] set_tag;
        logic [BYTE_W-1:0] del_tag;
    } t_tag_codes;

endpackage

// File: sv/kvcfp_if.sv
// Valid/ready channel interfaces of the frame parser: byte input, result output, config.
interface kvcfp_in_if;
    logic                          valid;
    logic                          ready;
    logic [kvcfp_pkg::BYTE_W-1:0]  data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvcfp_out_if;
    logic                          valid;
    logic                          ready;
    logic [kvcfp_pkg::BYTE_W-1:0]  out_byte;
    logic [kvcfp_pkg::CLASS_W-1:0] byte_class;
    logic [kvcfp_pkg::KIND_W-1:0]  command_kind;
    logic                          frame_done;
    logic                          frame_ok;

    modport source (output valid, output out_byte, output byte_class, output command_kind,
                    output frame_done, output frame_ok, input ready);
    modport sink   (input valid, input out_byte, input byte_class, input command_kind,
                    input frame_done, input frame_ok, output ready);
endinterface

interface kvcfp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kvcfp_pkg::CFG_IDX_W-1:0] index;
    logic [kvcfp_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/kvcfp_cfg_regs.sv
// Tag code configuration registers of the frame parser.
module kvcfp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_valid,
    input  logic [kvcfp_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [kvcfp_pkg::BYTE_W-1:0]  i_wr_data,
    output logic                          o_wr_ready,
    output kvcfp_pkg::t_tag_codes         o_tags
);

    logic [kvcfp_pkg::BYTE_W-1:0] r_set_tag;
    logic [kvcfp_pkg::BYTE_W-1:0] r_del_tag;

    // Writes are taken every cycle
    assign o_wr_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_tag <= kvcfp_pkg::SET_TAG_RESET;
            r_del_tag <= kvcfp_pkg::DEL_TAG_RESET;
        end else if (i_wr_valid) begin
            case (kvcfp_pkg::t_cfg_idx'(i_wr_index))
                kvcfp_pkg::CFG_SET_TAG: r_set_tag <= i_wr_data;
                kvcfp_pkg::CFG_DEL_TAG: r_del_tag <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_tags.set_tag = r_set_tag;
    assign o_tags.del_tag = r_del_tag;

endmodule

// File: sv/kvcfp_parse_step.sv
// Per-byte parse update: next frame state and the result beat for one input byte.
module kvcfp_parse_step (
    input  kvcfp_pkg::t_parse_state      i_state,
    input  kvcfp_pkg::t_tag_codes        i_tags,
    input  logic [kvcfp_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                         i_last_byte,
    output kvcfp_pkg::t_parse_state      o_next,
    output kvcfp_pkg::t_result           o_result
);

    kvcfp_pkg::t_parse_state  s;
    logic [kvcfp_pkg::LEN_W-1:0]   full_len;
    logic [kvcfp_pkg::LEN_W-1:0]   rem_dec;
    logic [kvcfp_pkg::CLASS_W-1:0] cls;
    kvcfp_pkg::t_phase        data_phase;
    kvcfp_pkg::t_phase        after_key;

    // Length is complete on the top byte; low bytes come from the shift register
    assign full_len = {i_data_byte, i_state.len_shift};
    assign rem_dec  = i_state.remaining - kvcfp_pkg::LEN_W'(1);

    // After the key blob a set goes on to the value, a delete is done
    assign after_key = (i_state.kind == kvcfp_pkg::KIND_SET) ? kvcfp_pkg::PH_VLEN
                                                             : kvcfp_pkg::PH_DONE;

    always_comb begin
        s          = i_state;
        cls        = kvcfp_pkg::CLS_HEADER;
        data_phase = kvcfp_pkg::PH_KDATA;

        if (!i_state.err) begin
            case (i_state.phase)
                kvcfp_pkg::PH_TAG: begin
                    if (i_data_byte == i_tags.set_tag) begin
                        s.kind  = kvcfp_pkg::KIND_SET;
                        s.phase = kvcfp_pkg::PH_KLEN;
                    end else if (i_data_byte == i_tags.del_tag) begin
                        s.kind  = kvcfp_pkg::KIND_DEL;
                        s.phase = kvcfp_pkg::PH_KLEN;
                    end else begin
                        s.kind = kvcfp_pkg::KIND_NONE;
                        s.err  = 1'b1;
                    end
                    s.len_shift = '0;
                    s.hdr_idx   = '0;
                end
                kvcfp_pkg::PH_KLEN, kvcfp_pkg::PH_VLEN: begin
                    data_phase = (i_state.phase == kvcfp_pkg::PH_KLEN) ? kvcfp_pkg::PH_KDATA
                                                                       : kvcfp_pkg::PH_VDATA;
                    if (i_state.hdr_idx == kvcfp_pkg::HDR_LAST_IDX) begin
                        s.hdr_idx   = '0;
                        s.len_shift = '0;
                        s.remaining = full_len;
                        if (full_len != '0) begin
                            s.phase = data_phase;
                        end else if (data_phase == kvcfp_pkg::PH_KDATA) begin
                            s.phase = after_key;
                        end else begin
                            s.phase = kvcfp_pkg::PH_DONE;
                        end
                    end else begin
                        // little-endian: byte lands at its header position
                        case (i_state.hdr_idx)
                            2'd0:    s.len_shift[7:0]   = i_data_byte;
                            2'd1:    s.len_shift[15:8]  = i_data_byte;
                            default: s.len_shift[23:16] = i_data_byte;
                        endcase
                        s.hdr_idx = i_state.hdr_idx + kvcfp_pkg::HDR_IDX_W'(1);
                    end
                end
                kvcfp_pkg::PH_KDATA, kvcfp_pkg::PH_VDATA: begin
                    cls = (i_state.phase == kvcfp_pkg::PH_KDATA) ? kvcfp_pkg::CLS_KEY
                                                                 : kvcfp_pkg::CLS_VALUE;
                    s.remaining = rem_dec;
                    if (rem_dec == '0) begin
                        s.phase = (i_state.phase == kvcfp_pkg::PH_KDATA) ? after_key
                                                                         : kvcfp_pkg::PH_DONE;
                    end
                end
                kvcfp_pkg::PH_DONE: begin
                    // trailing byte
                    s.err = 1'b1;
                end
                default: begin
                    s.err = 1'b1;
                end
            endcase
        end

        // Result beat
        o_result.out_byte     = i_data_byte;
        o_result.byte_class   = cls;
        o_result.command_kind = s.kind;
        o_result.frame_done   = i_last_byte;
        o_result.frame_ok     = i_last_byte && !s.err && (s.phase == kvcfp_pkg::PH_DONE);

        // Frame end returns to waiting for a tag
        if (i_last_byte) begin
            o_next.phase     = kvcfp_pkg::PH_TAG;
            o_next.kind      = kvcfp_pkg::KIND_NONE;
            o_next.len_shift = '0;
            o_next.hdr_idx   = '0;
            o_next.remaining = '0;
            o_next.err       = 1'b0;
        end else begin
            o_next = s;
        end
    end

endmodule

// File: sv/kv_command_frame_parser.sv
// Top level of the key/value command frame parser.
// Takes one frame byte per beat and returns one result beat per input beat, in order,
// in the cycle after the byte is accepted; a new byte can be accepted every cycle, also
// while a finished result waits in the output register, as long as that result is
// being taken. Each result comes from the combinational phase update (tag compare,
// length assembly and a 32-bit down counter) between the input handshake and the
// output register. Tag codes are written through the config channel, which is always
// ready; write them only while no frame byte is in flight.
module kv_command_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kvcfp_in_if.sink           i_in,
    kvcfp_out_if.source        o_out,
    kvcfp_cfg_if.sink          i_cfg
);

    kvcfp_pkg::t_tag_codes   tags;
    kvcfp_pkg::t_parse_state r_state;
    kvcfp_pkg::t_parse_state n_state;
    kvcfp_pkg::t_result      n_result;
    kvcfp_pkg::t_result      r_result;
    logic                    r_out_valid;
    logic                    in_accept;

    kvcfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_tags     (tags)
    );

    kvcfp_parse_step u_step (
        .i_state     (r_state),
        .i_tags      (tags),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_next      (n_state),
        .o_result    (n_result)
    );

    // Input is taken when the output register is empty or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Parse state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= kvcfp_pkg::PH_TAG;
            r_state.kind      <= kvcfp_pkg::KIND_NONE;
            r_state.len_shift <= '0;
            r_state.hdr_idx   <= '0;
            r_state.remaining <= '0;
            r_state.err       <= 1'b0;
            r_out_valid       <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_result.out_byte;
    assign o_out.byte_class   = r_result.byte_class;
    assign o_out.command_kind = r_result.command_kind;
    assign o_out.frame_done   = r_result.frame_done;
    assign o_out.frame_ok     = r_result.frame_ok;

endmodule

// File: sv/kvcfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
module kvcfp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [kvcfp_pkg::BYTE_W-1:0]  i_out_byte,
    input logic [kvcfp_pkg::CLASS_W-1:0] i_byte_class,
    input logic [kvcfp_pkg::KIND_W-1:0]  i_command_kind,
    input logic                          i_frame_done,
    input logic                          i_frame_ok
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_byte_class) && $stable(i_command_kind)
            && $stable(i_frame_done) && $stable(i_frame_ok))
        else $error("result beat changed while stalled");

    // Every accepted byte shows up as a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted byte gave no result beat");

    // Frame status only on the closing byte
    a_ok_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_ok |-> i_frame_done
            && (i_command_kind == kvcfp_pkg::KIND_SET || i_command_kind == kvcfp_pkg::KIND_DEL))
        else $error("frame_ok without a finished, recognized frame");

    // Key bytes only follow a recognized tag
    a_key_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_class == kvcfp_pkg::CLS_KEY
            |-> i_command_kind == kvcfp_pkg::KIND_SET || i_command_kind == kvcfp_pkg::KIND_DEL)
        else $error("key byte without a command kind");

    // Value bytes belong to set commands only
    a_value_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_class == kvcfp_pkg::CLS_VALUE
            |-> i_command_kind == kvcfp_pkg::KIND_SET)
        else $error("value byte outside a set command");

endmodule

bind kv_command_frame_parser kvcfp_checker u_kvcfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_byte_class   (o_out.byte_class),
    .i_command_kind (o_out.command_kind),
    .i_frame_done   (o_out.frame_done),
    .i_frame_ok     (o_out.frame_ok)
);

// File: tb/sv/tb_kv_command_frame_parser.sv
// Self-checking testbench of the key/value command frame parser: random and directed frames.
module tb_kv_command_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import kvcfp_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_BLOB    = 12;    // data bytes sent at most per blob
    localparam int HOLD_AT     = 40;    // result count at which the long hold-off starts
    localparam int HOLD_LEN    = 150;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_byte;

    logic i_clk;
    logic i_rst_n;

    kvcfp_in_if  in_ch ();
    kvcfp_out_if out_ch ();
    kvcfp_cfg_if cfg_ch ();

    kv_command_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Bytes waiting to be sent and parse results waiting to come back
    t_frame_byte frame_bytes_q[$];
    t_result     parsed_beats_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int results_seen;
    int hold_left;
    bit hold_done;
    int cycle_count;
    int queued_items;

    // Parser state of the predictor, and its copy of the tag codes
    logic [BYTE_W-1:0] tag_set;
    logic [BYTE_W-1:0] tag_del;
    t_phase            ps_phase;
    logic [KIND_W-1:0] ps_kind;
    logic [LEN_W-1:0]  ps_len;
    logic [1:0]        ps_idx;
    logic [LEN_W-1:0]  ps_remaining;
    logic              ps_err;

    function automatic void clear_parse();
        ps_phase     = PH_TAG;
        ps_kind      = KIND_NONE;
        ps_len       = '0;
        ps_idx       = '0;
        ps_remaining = '0;
        ps_err       = 1'b0;
    endfunction

    // Where parsing goes once a blob is finished: a set key is followed by a value
    function automatic t_phase phase_after_blob(input t_phase data_phase);
        return (data_phase == PH_KDATA && ps_kind == KIND_SET) ? PH_VLEN : PH_DONE;
    endfunction

    // Advance the parse by one byte and give the result beat it produces
    function automatic t_result parse_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_result           r;
        logic [CLASS_W-1:0] cls;
        t_phase            dp;
        cls = CLS_HEADER;
        if (!ps_err) begin
            case (ps_phase)
                PH_TAG: begin
                    if (b == tag_set) begin
                        ps_kind  = KIND_SET;
                        ps_phase = PH_KLEN;
                    end else if (b == tag_del) begin
                        ps_kind  = KIND_DEL;
                        ps_phase = PH_KLEN;
                    end else begin
                        ps_kind = KIND_NONE;
                        ps_err  = 1'b1;
                    end
                    ps_len = '0;
                    ps_idx = '0;
                end
                PH_KLEN, PH_VLEN: begin
                    ps_len = ps_len | (LEN_W'(b) << (8 * ps_idx));
                    if (ps_idx == HDR_LAST_IDX) begin
                        dp           = (ps_phase == PH_KLEN) ? PH_KDATA : PH_VDATA;
                        ps_idx       = '0;
                        ps_remaining = ps_len;
                        ps_len       = '0;
                        ps_phase     = (ps_remaining == 0) ? phase_after_blob(dp) : dp;
                    end else begin
                        ps_idx = ps_idx + 2'd1;
                    end
                end
                PH_KDATA, PH_VDATA: begin
                    cls = (ps_phase == PH_KDATA) ? CLS_KEY : CLS_VALUE;
                    ps_remaining = ps_remaining - 1;
                    if (ps_remaining == 0)
                        ps_phase = phase_after_blob(ps_phase);
                end
                default: begin
                    // byte past the end of a complete frame
                    ps_err = 1'b1;
                end
            endcase
        end
        r.out_byte     = b;
        r.byte_class   = cls;
        r.command_kind = ps_kind;
        r.frame_done   = last;
        r.frame_ok     = last && !ps_err && ps_phase == PH_DONE;
        if (last)
            clear_parse();
        return r;
    endfunction

    // Clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Byte sender: offers queued bytes, predicts on each accepted beat
    always @(posedge i_clk) begin : byte_driver
        t_frame_byte nb;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                parsed_beats_q.push_back(parse_frame_byte(in_ch.data_byte, in_ch.last_byte));
            if (!in_ch.valid || in_ch.ready) begin
                if (frame_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nb = frame_bytes_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= nb.data;
                    in_ch.last_byte <= nb.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result receiver: compares each beat, throttles ready, does one long hold-off
    always @(posedge i_clk) begin : result_monitor
        t_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (parsed_beats_q.size() == 0) begin
                    $error("result beat with no byte outstanding: out_byte %0d",
                           out_ch.out_byte);
                    fail_count++;
                end else begin
                    exp_r = parsed_beats_q.pop_front();
                    check_field("out_byte", exp_r.out_byte, out_ch.out_byte);
                    check_field("byte_class", exp_r.byte_class, out_ch.byte_class);
                    check_field("command_kind", exp_r.command_kind, out_ch.command_kind);
                    check_field("frame_done", exp_r.frame_done, out_ch.frame_done);
                    check_field("frame_ok", exp_r.frame_ok, out_ch.frame_ok);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Build one frame: tag, key blob, optional value blob, trailing bytes, optional cut
    task automatic queue_frame(input logic [BYTE_W-1:0] tag, input logic [LEN_W-1:0] key_len,
                               input logic [LEN_W-1:0] val_len, input bit with_value,
                               input int trailing, input int keep);
        logic [BYTE_W-1:0] bytes[$];
        int n;
        bytes.push_back(tag);
        for (int i = 0; i < 4; i++)
            bytes.push_back(key_len[8*i +: 8]);
        n = (key_len > MAX_BLOB) ? MAX_BLOB : int'(key_len);
        for (int i = 0; i < n; i++)
            bytes.push_back(BYTE_W'($urandom));
        if (with_value) begin
            for (int i = 0; i < 4; i++)
                bytes.push_back(val_len[8*i +: 8]);
            n = (val_len > MAX_BLOB) ? MAX_BLOB : int'(val_len);
            for (int i = 0; i < n; i++)
                bytes.push_back(BYTE_W'($urandom));
        end
        for (int i = 0; i < trailing; i++)
            bytes.push_back(BYTE_W'($urandom));
        if (keep > 0) begin
            while (bytes.size() > keep)
                void'(bytes.pop_back());
        end
        foreach (bytes[i])
            frame_bytes_q.push_back('{data: bytes[i], last: (i == bytes.size() - 1)});
        queued_items += bytes.size();
    endtask

    // Mostly short blobs; now and then a full 32-bit or extreme length, cut short
    function automatic logic [LEN_W-1:0] random_length();
        int p;
        p = $urandom_range(99);
        if (p < 88)
            return LEN_W'($urandom_range(0, 6));
        if (p < 94)
            return LEN_W'($urandom);
        if (p < 97)
            return 32'hFFFF_FFFF;
        return 32'd1 << $urandom_range(0, 31);
    endfunction

    task automatic queue_random_frames(input int n_items);
        int               pick;
        logic [BYTE_W-1:0] tag;
        int               trail;
        int               keep;
        int               target;
        target = queued_items + n_items;
        while (queued_items < target) begin
            pick = $urandom_range(99);
            if (pick < 45)
                tag = tag_set;
            else if (pick < 85)
                tag = tag_del;
            else
                tag = BYTE_W'($urandom);
            trail = ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
            keep  = ($urandom_range(99) < 12) ? $urandom_range(1, 20) : 0;
            queue_frame(tag, random_length(), random_length(),
                        (tag == tag_set) ^ ($urandom_range(99) < 5), trail, keep);
        end
    endtask

    // Wait until the block has nothing in flight, then a short settling pause
    task automatic drain();
        do
            @(negedge i_clk);
        while (frame_bytes_q.size() != 0 || in_ch.valid || parsed_beats_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tag(input t_cfg_idx idx, input logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SET_TAG)
            tag_set = val;
        else
            tag_del = val;
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_SET_TAG;
        cfg_ch.data      = '0;
        tag_set          = SET_TAG_RESET;
        tag_del          = DEL_TAG_RESET;
        clear_parse();
        send_idle_pct    = 16;
        recv_idle_pct    = 58;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at reset tag codes
        queue_frame(tag_set, 32'd1, 32'd0, 1'b1, 0, 0);           // set, empty value blob
        queue_frame(tag_del, 32'd0, 32'd0, 1'b0, 0, 0);           // delete, empty key
        queue_frame(8'h00, 32'hFFFF_FFFF, 32'd0, 1'b0, 0, 3);     // unknown tag, ignored rest
        queue_frame(tag_del, 32'd1, 32'd0, 1'b0, 1, 0);           // trailing byte
        queue_frame(tag_set, 32'd0, 32'd0, 1'b1, 0, 3);           // ends inside key length
        queue_frame(8'hFF, 32'd0, 32'd0, 1'b0, 0, 1);             // lone unknown tag
        queue_random_frames(420);
        drain();

        // Extreme tag codes, receiver mostly ready
        send_idle_pct = 58;
        recv_idle_pct = 16;
        write_tag(CFG_SET_TAG, 8'h00);
        write_tag(CFG_DEL_TAG, 8'hFF);
        queue_random_frames(450);
        drain();

        // Equal tag codes: every match counts as a set; no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tag(CFG_SET_TAG, 8'h5A);
        write_tag(CFG_DEL_TAG, 8'h5A);
        queue_frame(8'h5A, 32'd2, 32'd1, 1'b1, 0, 0);
        queue_random_frames(150);
        drain();

        // Swapped extremes, then random codes
        write_tag(CFG_SET_TAG, 8'hFF);
        write_tag(CFG_DEL_TAG, 8'h00);
        queue_random_frames(150);
        drain();
        write_tag(CFG_SET_TAG, BYTE_W'($urandom));
        write_tag(CFG_DEL_TAG, BYTE_W'($urandom));
        queue_random_frames(150);
        drain();

        if (fail_count == 0 && parsed_beats_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
